>>> rtl/core/rwlc_pkg.sv
// shared codes and flag types for the reader-writer lock controller
package rwlc_pkg;

  // lock event codes carried in the mode field
  localparam logic [2:0] MODE_ADD_READER    = 3'd0;
  localparam logic [2:0] MODE_FINISH_READER = 3'd1;
  localparam logic [2:0] MODE_ADD_WRITER    = 3'd2;
  localparam logic [2:0] MODE_FINISH_WRITER = 3'd3;
  localparam logic [2:0] MODE_INVALIDATE    = 3'd4;

  typedef enum logic [1:0] {
    WS_NONE      = 2'd0,
    WS_PENDING   = 2'd1,
    WS_PROCESSED = 2'd2,
    WS_INVALID   = 2'd3
  } ws_e;

  typedef enum logic [1:0] {
    WR_SUCCESS  = 2'd0,
    WR_PENDING  = 2'd1,
    WR_CONFLICT = 2'd2,
    WR_INVALID  = 2'd3
  } wr_e;

  // per-event status flags from the event engine
  typedef struct packed {
    logic reader_granted;
    wr_e  writer_result;
    logic resume_writer;
    logic misuse;
  } evt_flags_t;

endpackage

>>> rtl/core/reader_writer_lock_control.sv
// reader-writer lock controller top level: input stage, lock state and result stage
// an accepted beat is registered first in the input stage, then its result in the result stage
// throughput: one event per cycle while the result stage is not stalled; the lock state
//   register updates in the same edge that captures the result, so the next event sees it at once
// reset: rst_ni asynchronous active low clears the stage valids and the lock
//   state (count zero, no writer, held id zero)
module reader_writer_lock_control
  import rwlc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // event channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            mode_i,
  input  logic [ID_BITS-1:0]    writer_id_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  reader_granted_o,
  output logic [1:0]            writer_result_o,
  output logic                  resume_writer_o,
  output logic [ID_BITS-1:0]    resume_id_o,
  output logic [COUNT_BITS-1:0] reader_count_now_o,
  output logic [1:0]            writer_state_now_o,
  output logic                  misuse_o
);

  // input stage
  logic               in_vld_q;
  logic [2:0]         mode_q;
  logic [ID_BITS-1:0] wid_q;

  // lock state
  logic [COUNT_BITS-1:0] count_q, count_d;
  ws_e                   ws_q, ws_d;
  logic [ID_BITS-1:0]    held_id_q, held_id_d;
  logic                  held_q, held_d;

  // result stage
  logic                  out_vld_q;
  logic [COUNT_BITS-1:0] res_count_q;
  ws_e                   res_ws_q;
  logic [ID_BITS-1:0]    res_rid_q, rid_d;
  evt_flags_t            res_flags_q, flags_d;

  logic out_free;   // result stage can take a new beat
  logic fire;       // input stage beat is processed this cycle
  logic in_take;    // input stage loads a new beat

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_take    = !in_vld_q || out_free;
  assign in_stall_o = !in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= in_valid_i;
    end
  end

  // payload only loads on an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_take && in_valid_i) begin
      mode_q <= mode_i;
      wid_q  <= writer_id_i;
    end
  end

  rwlc_engine #(
    .COUNT_BITS (COUNT_BITS),
    .ID_BITS    (ID_BITS)
  ) u_engine (
    .mode_i      (mode_q),
    .writer_id_i (wid_q),
    .count_i     (count_q),
    .ws_i        (ws_q),
    .held_id_i   (held_id_q),
    .held_i      (held_q),
    .count_o     (count_d),
    .ws_o        (ws_d),
    .held_id_o   (held_id_d),
    .held_o      (held_d),
    .resume_id_o (rid_d),
    .flags_o     (flags_d)
  );

  // lock state commits together with the result capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ws_q      <= WS_NONE;
      held_id_q <= '0;
      held_q    <= 1'b0;
    end else if (fire) begin
      count_q   <= count_d;
      ws_q      <= ws_d;
      held_id_q <= held_id_d;
      held_q    <= held_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_count_q <= count_d;
      res_ws_q    <= ws_d;
      res_rid_q   <= rid_d;
      res_flags_q <= flags_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign reader_granted_o   = res_flags_q.reader_granted;
  assign writer_result_o    = res_flags_q.writer_result;
  assign resume_writer_o    = res_flags_q.resume_writer;
  assign resume_id_o        = res_rid_q;
  assign reader_count_now_o = res_count_q;
  assign writer_state_now_o = res_ws_q;
  assign misuse_o           = res_flags_q.misuse;

  // a resumed writer leaves the lock processed with no readers
  a_resume_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_flags_q.resume_writer |->
      res_ws_q == WS_PROCESSED && res_count_q == '0)
    else $error("resume without processed empty lock");

  // readers are granted only with no writer present
  a_grant_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_flags_q.reader_granted |-> res_ws_q == WS_NONE)
    else $error("reader granted while writer present");

  // a pending or processed lock always holds a writer request
  a_writer_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ws_q == WS_PENDING || ws_q == WS_PROCESSED) |-> held_q)
    else $error("writer status without held request");

  // the input side only stalls when a full result stage is stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without backpressure");

  // a stalled input beat leaves the lock state untouched
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(count_q) && $stable(ws_q) && $stable(held_q))
    else $error("lock state changed without an event");

endmodule

>>> rtl/core/rwlc_engine.sv
// next-state and result logic for one lock event
module rwlc_engine
  import rwlc_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16,
  parameter int unsigned ID_BITS    = 16
) (
  input  logic [2:0]            mode_i,
  input  logic [ID_BITS-1:0]    writer_id_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  ws_e                   ws_i,
  input  logic [ID_BITS-1:0]    held_id_i,
  input  logic                  held_i,
  output logic [COUNT_BITS-1:0] count_o,
  output ws_e                   ws_o,
  output logic [ID_BITS-1:0]    held_id_o,
  output logic                  held_o,
  output logic [ID_BITS-1:0]    resume_id_o,
  output evt_flags_t            flags_o
);

  logic cnt_zero;
  logic cnt_one;
  logic cnt_max;
  logic same_writer;
  logic proceed;

  assign cnt_zero    = (count_i == '0);
  assign cnt_one     = (count_i == COUNT_BITS'(1));
  assign cnt_max     = &count_i;
  assign same_writer = held_i && (held_id_i == writer_id_i);

  always_comb begin
    count_o     = count_i;
    ws_o        = ws_i;
    held_id_o   = held_id_i;
    held_o      = held_i;
    resume_id_o = '0;
    flags_o     = '{reader_granted: 1'b0, writer_result: WR_SUCCESS,
                    resume_writer: 1'b0, misuse: 1'b0};
    proceed     = 1'b0;
    unique case (mode_i)
      MODE_ADD_READER: begin
        if (ws_i == WS_NONE) begin
          if (cnt_max) begin
            flags_o.misuse = 1'b1;
          end else begin
            count_o                = count_i + COUNT_BITS'(1);
            flags_o.reader_granted = 1'b1;
          end
        end
      end
      MODE_FINISH_READER: begin
        if (ws_i != WS_INVALID) begin
          if (cnt_zero) begin
            flags_o.misuse = 1'b1;
          end else begin
            count_o = count_i - COUNT_BITS'(1);
            // last reader out hands the lock to the waiting writer
            if (cnt_one && ws_i == WS_PENDING && held_i) begin
              ws_o                  = WS_PROCESSED;
              flags_o.resume_writer = 1'b1;
              resume_id_o           = held_id_i;
            end
          end
        end
      end
      MODE_ADD_WRITER: begin
        unique case (ws_i)
          WS_INVALID:   flags_o.writer_result = WR_INVALID;
          WS_PROCESSED: flags_o.writer_result = same_writer ? WR_SUCCESS : WR_CONFLICT;
          WS_PENDING: begin
            if (same_writer) begin
              proceed = 1'b1;
            end else begin
              flags_o.writer_result = WR_CONFLICT;
            end
          end
          default: begin
            ws_o    = WS_PENDING;
            proceed = 1'b1;
          end
        endcase
        if (proceed) begin
          held_id_o = writer_id_i;
          held_o    = 1'b1;
          if (cnt_zero) begin
            ws_o                  = WS_PROCESSED;
            flags_o.writer_result = WR_SUCCESS;
          end else begin
            flags_o.writer_result = WR_PENDING;
          end
        end
      end
      MODE_FINISH_WRITER: begin
        flags_o.misuse = !(cnt_zero && ws_i == WS_PROCESSED);
        held_id_o      = '0;
        held_o         = 1'b0;
        count_o        = '0;
        ws_o           = WS_INVALID;
      end
      MODE_INVALIDATE: begin
        count_o = '0;
        ws_o    = WS_INVALID;
      end
      default: begin
      end
    endcase
  end

endmodule
